/* hdl/lwt_pkg.sv */
package lwt_pkg;

   localparam int POSITION_WIDTH = 32;
   localparam int QUEUE_DEPTH    = 4;
   localparam int OUT_WIDTH      = 32;

   localparam logic [7:0] NL_CHAR    = 8'h0A;
   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] QUOTE_CHAR = 8'h22;

   typedef struct packed {
      logic [OUT_WIDTH-1:0] token_start;
      logic [OUT_WIDTH-1:0] token_length;
      logic [OUT_WIDTH-1:0] line_offset;
      logic                 is_quoted;
   } token_type;

   // one queue entry: the tokens that one text byte produced
   typedef struct packed {
      logic      two;
      token_type tok0;
      token_type tok1;
   } entry_type;

endpackage

/* hdl/lwt_req_if.sv */
interface lwt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

/* hdl/lwt_rsp_if.sv */
interface lwt_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] token_start;
   logic [31:0] token_length;
   logic [31:0] line_offset;
   logic        is_quoted;
   logic        run_last;

   modport source (output valid, output token_start, output token_length,
                   output line_offset, output is_quoted, output run_last, input ready);
   modport sink   (input valid, input token_start, input token_length,
                   input line_offset, input is_quoted, input run_last, output ready);
endinterface

/* hdl/lwt_front.sv */
module lwt_front #(
   parameter int POSITION_WIDTH = lwt_pkg::POSITION_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   lwt_req_if.sink            req_if,
   input  logic               q_full,
   output logic               push,
   output lwt_pkg::entry_type push_entry
);

   localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};

   logic [POSITION_WIDTH-1:0] pos_ff, pos_in;
   logic [POSITION_WIDTH-1:0] line_base_ff, line_base_in;
   logic [POSITION_WIDTH-1:0] word_base_ff, word_base_in;
   logic [POSITION_WIDTH-1:0] quote_pos_ff, quote_pos_in;
   logic                      quote_open_ff, quote_open_in;

   logic                      accept;
   logic                      is_nl, is_space, is_quote, last;
   logic [POSITION_WIDTH-1:0] nxt, q_start, ws_new;
   logic                      tok_a_v, tok_b_v;
   lwt_pkg::token_type        tok_a, tok_b;

   function automatic logic [POSITION_WIDTH-1:0] sat_inc(input logic [POSITION_WIDTH-1:0] v);
      return (v == POS_MAX) ? v : v + 1'b1;
   endfunction

   // report low 32 bits, zero-extended when positions are narrower
   function automatic logic [lwt_pkg::OUT_WIDTH-1:0] to_out(
      input logic [POSITION_WIDTH-1:0] v);
      logic [POSITION_WIDTH+lwt_pkg::OUT_WIDTH-1:0] w;
      w = {{lwt_pkg::OUT_WIDTH{1'b0}}, v};
      return w[lwt_pkg::OUT_WIDTH-1:0];
   endfunction

   assign req_if.ready = !q_full;
   assign accept       = req_if.valid && !q_full;

   assign is_nl    = (req_if.text_byte == lwt_pkg::NL_CHAR);
   assign is_space = (req_if.text_byte == lwt_pkg::SPACE_CHAR);
   assign is_quote = (req_if.text_byte == lwt_pkg::QUOTE_CHAR);
   assign last     = req_if.end_of_text;

   assign nxt     = sat_inc(pos_ff);
   assign q_start = sat_inc(quote_pos_ff);
   assign ws_new  = is_space ? nxt : word_base_ff;

   always_comb begin
      tok_a_v = 1'b0;
      tok_a.token_start  = to_out(word_base_ff);
      tok_a.token_length = to_out(pos_ff - word_base_ff);
      tok_a.line_offset  = to_out(line_base_ff);
      tok_a.is_quoted    = 1'b0;
      if (is_nl || is_space) begin
         tok_a_v = (word_base_ff < pos_ff);
      end else if (is_quote && quote_open_ff) begin
         tok_a_v            = (pos_ff > q_start);
         tok_a.token_start  = to_out(q_start);
         tok_a.token_length = to_out(pos_ff - q_start);
         tok_a.is_quoted    = 1'b1;
      end

      // word that the final byte closes
      tok_b_v = !is_nl && last && (ws_new < nxt);
      tok_b.token_start  = to_out(ws_new);
      tok_b.token_length = to_out(nxt - ws_new);
      tok_b.line_offset  = to_out(line_base_ff);
      tok_b.is_quoted    = 1'b0;

      if (tok_a_v) begin
         push_entry.two  = tok_b_v;
         push_entry.tok0 = tok_a;
         push_entry.tok1 = tok_b;
      end else begin
         push_entry.two  = 1'b0;
         push_entry.tok0 = tok_b;
         push_entry.tok1 = tok_b;
      end
      push = accept && (tok_a_v || tok_b_v);
   end

   always_comb begin
      pos_in        = pos_ff;
      line_base_in  = line_base_ff;
      word_base_in  = word_base_ff;
      quote_pos_in  = quote_pos_ff;
      quote_open_in = quote_open_ff;
      if (accept) begin
         if (last) begin
            pos_in        = '0;
            line_base_in  = '0;
            word_base_in  = '0;
            quote_pos_in  = '0;
            quote_open_in = 1'b0;
         end else begin
            pos_in = nxt;
            if (is_nl) begin
               line_base_in  = nxt;
               word_base_in  = nxt;
               quote_pos_in  = '0;
               quote_open_in = 1'b0;
            end else if (is_space) begin
               word_base_in = nxt;
            end else if (is_quote) begin
               if (!quote_open_ff) begin
                  quote_open_in = 1'b1;
                  quote_pos_in  = pos_ff;
               end else begin
                  quote_open_in = 1'b0;
                  quote_pos_in  = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         line_base_ff  <= '0;
         word_base_ff  <= '0;
         quote_pos_ff  <= '0;
         quote_open_ff <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         line_base_ff  <= line_base_in;
         word_base_ff  <= word_base_in;
         quote_pos_ff  <= quote_pos_in;
         quote_open_ff <= quote_open_in;
      end
   end

endmodule

/* hdl/lwt_queue.sv */
module lwt_queue #(
   parameter int DEPTH = lwt_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lwt_pkg::entry_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output lwt_pkg::entry_type pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   lwt_pkg::entry_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full      = (count_ff == CNT_FULL);
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* hdl/lwt_back.sv */
module lwt_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  lwt_pkg::entry_type q_data,
   output logic               q_pop,
   lwt_rsp_if.source          rsp_if
);

   logic               out_valid_ff, out_valid_in;
   logic               out_last_ff, out_last_in;
   lwt_pkg::token_type out_tok_ff, out_tok_in;
   logic               pend_ff, pend_in;
   lwt_pkg::token_type pend_tok_ff, pend_tok_in;
   logic               out_free;

   assign out_free = !out_valid_ff || rsp_if.ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_last_in  = out_last_ff;
      out_tok_in   = out_tok_ff;
      pend_in      = pend_ff;
      pend_tok_in  = pend_tok_ff;
      q_pop        = 1'b0;
      if (out_free) begin
         if (pend_ff) begin
            // second token of the same byte
            out_valid_in = 1'b1;
            out_tok_in   = pend_tok_ff;
            out_last_in  = 1'b1;
            pend_in      = 1'b0;
         end else if (q_valid) begin
            q_pop        = 1'b1;
            out_valid_in = 1'b1;
            out_tok_in   = q_data.tok0;
            out_last_in  = !q_data.two;
            pend_in      = q_data.two;
            pend_tok_in  = q_data.tok1;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      out_last_ff <= out_last_in;
      out_tok_ff  <= out_tok_in;
      pend_tok_ff <= pend_tok_in;
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.token_start  = out_tok_ff.token_start;
   assign rsp_if.token_length = out_tok_ff.token_length;
   assign rsp_if.line_offset  = out_tok_ff.line_offset;
   assign rsp_if.is_quoted    = out_tok_ff.is_quoted;
   assign rsp_if.run_last     = out_last_ff;

endmodule

/* hdl/log_line_word_tokenizer_unit.sv */
// Log line word tokenizer.
// req_if takes one text byte per beat (text_byte, end_of_text). Bytes split
// into lines at newlines; each space-delimited word and each non-empty span
// between a quote pair on one line gives a token descriptor on rsp_if
// (start, length, line start, quoted flag). run_last flags the final
// descriptor caused by a byte; a byte gives zero, one or two descriptors.
// end_of_text closes the last line and restarts offsets at zero afterwards.
// The first descriptor of a byte passes through the queue and the output
// register before it is valid on rsp_if. The front takes one byte per cycle
// while the queue is not full; the back sends one descriptor per cycle while
// rsp_if is ready, so a byte giving two descriptors sends them one after
// the other, and the QUEUE_DEPTH-entry queue absorbs the burst of entries.
// When rsp_if stalls, the queue fills and req_if.ready drops once it is full;
// no descriptor is lost. Synchronous reset clears positions, the quote flag,
// the queue and the output stage; no descriptor is valid after reset.
// Positions are POSITION_WIDTH bits, saturating; reported in their low 32.
module log_line_word_tokenizer_unit #(
   parameter int POSITION_WIDTH = lwt_pkg::POSITION_WIDTH,
   parameter int QUEUE_DEPTH    = lwt_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   lwt_req_if.sink    req_if,
   lwt_rsp_if.source  rsp_if
);

   // front -> queue
   logic               push;
   lwt_pkg::entry_type push_entry;
   logic               q_full;

   // queue -> back
   logic               q_valid;
   logic               q_pop;
   lwt_pkg::entry_type q_data;

   // classify bytes, track line/word/quote state, build descriptors
   lwt_front #(
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // decouples byte intake from descriptor delivery
   lwt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_entry),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_data  (q_data)
   );

   // serializes entries into single descriptors behind an output register
   lwt_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_data  (q_data),
      .q_pop   (q_pop),
      .rsp_if  (rsp_if)
   );

endmodule
